// File: src/pssl_pkg.sv
// ----------------------------------------------------------------------------
// pssl_pkg
// Shared widths, codes and types of the piston setpoint slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pssl_pkg;

   // Data formats
   localparam int POS_BITS   = 32;              // signed Q16.16 positions
   localparam int FRAC_BITS  = 16;              // extension fraction bits
   localparam int EXT_BITS   = FRAC_BITS + 1;   // 0 .. full stroke inclusive
   localparam int TIME_BITS  = 16;              // time step, Q0.16
   localparam int TIME_FRAC  = 16;
   localparam int VEL_BITS   = POS_BITS - 1;
   localparam int SPAN_BITS  = POS_BITS + 1;    // exact stroke difference
   localparam int REM_BITS   = POS_BITS + 2;    // divider remainder
   localparam int CNT_BITS   = $clog2(FRAC_BITS);
   localparam int MUL_B_BITS = EXT_BITS + 1;    // signed view of ext or time step
   localparam int PROD_BITS  = SPAN_BITS + MUL_B_BITS;

   localparam logic [EXT_BITS-1:0] FULL_EXT = EXT_BITS'(1) << FRAC_BITS;

   // Configuration port
   localparam int NUM_REGS  = 5;
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = $clog2(4 * NUM_REGS);

   localparam logic signed [POS_BITS-1:0] STROKE_UPPER_RESET = POS_BITS'(65536);

   typedef enum logic [ADDR_BITS-3:0] {
      REG_STROKE_LOWER   = 3'd0,
      REG_STROKE_UPPER   = 3'd1,
      REG_VELOCITY_LIMIT = 3'd2,
      REG_LOCK_IDLE      = 3'd3,
      REG_UNIT_ENABLED   = 3'd4
   } pssl_reg_type;

   typedef enum logic [1:0] {
      MODE_HOLD     = 2'd0,
      MODE_EXTEND   = 2'd1,
      MODE_CONTRACT = 2'd2,
      MODE_POSITION = 2'd3
   } pssl_mode_type;

   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_DRIVE   = 1'b1;

   typedef struct packed {
      logic signed [POS_BITS-1:0] stroke_lower;
      logic signed [POS_BITS-1:0] stroke_upper;
      logic [VEL_BITS-1:0]        velocity_limit;
      logic                       lock_idle;
      logic                       unit_enabled;
   } pssl_cfg_type;

   localparam pssl_cfg_type CFG_RESET = '{
      stroke_lower:   '0,
      stroke_upper:   STROKE_UPPER_RESET,
      velocity_limit: '0,
      lock_idle:      1'b0,
      unit_enabled:   1'b1
   };

endpackage

`default_nettype wire

// File: src/pssl_req_if.sv
// ----------------------------------------------------------------------------
// pssl_req_if
// Input channel: measure and drive transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pssl_req_if import pssl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [POS_BITS-1:0] measured_position;
   logic                       position_valid;
   logic [1:0]                 drive_mode;
   logic [EXT_BITS-1:0]        target_fraction;
   logic [TIME_BITS-1:0]       time_step;

   modport source (
      output valid, kind, measured_position, position_valid, drive_mode,
             target_fraction, time_step,
      input  ready
   );

   modport sink (
      input  valid, kind, measured_position, position_valid, drive_mode,
             target_fraction, time_step,
      output ready
   );
endinterface

`default_nettype wire

// File: src/pssl_rsp_if.sv
// ----------------------------------------------------------------------------
// pssl_rsp_if
// Result channel: setpoint, travel limits and drive flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pssl_rsp_if import pssl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [POS_BITS-1:0] servo_setpoint;
   logic signed [POS_BITS-1:0] travel_lower;
   logic signed [POS_BITS-1:0] travel_upper;
   logic                       drive_on;
   logic [EXT_BITS-1:0]        extension_now;

   modport source (
      output valid, servo_setpoint, travel_lower, travel_upper, drive_on,
             extension_now,
      input  ready
   );

   modport sink (
      input  valid, servo_setpoint, travel_lower, travel_upper, drive_on,
             extension_now,
      output ready
   );
endinterface

`default_nettype wire

// File: src/pssl_csr.sv
// ----------------------------------------------------------------------------
// pssl_csr
// APB-style configuration registers: stroke, velocity limit, lock, enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pssl_csr import pssl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready,
   output pssl_cfg_type         cfg
);

   pssl_cfg_type cfg_ff, cfg_in;
   pssl_reg_type reg_index;

   assign reg_index  = pssl_reg_type'(csr_paddr[ADDR_BITS-1:2]);
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_index)
            REG_STROKE_LOWER:   cfg_in.stroke_lower   = csr_pwdata[POS_BITS-1:0];
            REG_STROKE_UPPER:   cfg_in.stroke_upper   = csr_pwdata[POS_BITS-1:0];
            REG_VELOCITY_LIMIT: cfg_in.velocity_limit = csr_pwdata[VEL_BITS-1:0];
            REG_LOCK_IDLE:      cfg_in.lock_idle      = csr_pwdata[0];
            REG_UNIT_ENABLED:   cfg_in.unit_enabled   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_STROKE_LOWER:   csr_prdata = cfg_ff.stroke_lower;
         REG_STROKE_UPPER:   csr_prdata = cfg_ff.stroke_upper;
         REG_VELOCITY_LIMIT: csr_prdata = DATA_BITS'(cfg_ff.velocity_limit);
         REG_LOCK_IDLE:      csr_prdata = DATA_BITS'(cfg_ff.lock_idle);
         REG_UNIT_ENABLED:   csr_prdata = DATA_BITS'(cfg_ff.unit_enabled);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/piston_setpoint_slew_limiter_core.sv
// ----------------------------------------------------------------------------
// piston_setpoint_slew_limiter_core
// Setpoint, travel-limit and drive-enable generator for a linear actuator.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and holds req ready low while it
// works. Every enabled transaction first finds the normalized extension of
// the present position with a restoring divider that resolves one quotient
// bit per cycle, so the divide dominates the time of a transaction, and a
// drive transaction also waits on rsp ready. The divide is skipped when the
// stroke is empty or inverted, or when the position lies outside the stroke
// or on one of its ends; the extension is then set directly. A drive then
// uses one shared 33x18 multiplier twice, first to scale the target onto the
// stroke and then to form the velocity step, and the result sits in an
// output register until taken. With unit_enabled low, transactions are taken
// and dropped.
`default_nettype none

module piston_setpoint_slew_limiter_core import pssl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pssl_req_if.sink             req_bus,
   pssl_rsp_if.source           rsp_bus,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_CHECK = 9'b000000100,
      ST_DIV   = 9'b000001000,
      ST_STORE = 9'b000010000,
      ST_SCALE = 9'b000100000,
      ST_STEP  = 9'b001000000,
      ST_MOVE  = 9'b010000000,
      ST_SEND  = 9'b100000000
   } state_type;

   function automatic logic signed [POS_BITS-1:0] clamp_pos(
      input logic signed [POS_BITS-1:0] v,
      input logic signed [POS_BITS-1:0] lo,
      input logic signed [POS_BITS-1:0] hi
   );
      logic signed [POS_BITS-1:0] t;
      t = (v < lo) ? lo : v;
      t = (t > hi) ? hi : t;
      return t;
   endfunction

   pssl_cfg_type cfg;

   // control and architectural state
   state_type                  state_ff, state_in;
   logic                       seeded_ff, seeded_in;
   logic signed [POS_BITS-1:0] command_ff, command_in;
   logic signed [POS_BITS-1:0] present_pos_ff, present_pos_in;
   logic [EXT_BITS-1:0]        present_frac_ff, present_frac_in;

   // transaction latches and datapath
   logic                        kind_ff, kind_in;
   pssl_mode_type               mode_ff, mode_in;
   logic [EXT_BITS-1:0]         tfrac_ff, tfrac_in;
   logic [TIME_BITS-1:0]        dt_ff, dt_in;
   logic                        upd_frac_ff, upd_frac_in;
   logic signed [SPAN_BITS-1:0] span_ff, span_in;
   logic [REM_BITS-1:0]         rem_ff, rem_in;
   logic [FRAC_BITS-1:0]        quo_ff, quo_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic [EXT_BITS-1:0]         ext_ff, ext_in;
   logic signed [POS_BITS-1:0]  tgt_pos_ff, tgt_pos_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [POS_BITS-1:0]  lim_lo_ff, lim_lo_in;
   logic signed [POS_BITS-1:0]  lim_hi_ff, lim_hi_in;

   // result register
   logic signed [POS_BITS-1:0] out_setpoint_ff, out_setpoint_in;
   logic signed [POS_BITS-1:0] out_lower_ff, out_lower_in;
   logic signed [POS_BITS-1:0] out_upper_ff, out_upper_in;
   logic                       out_drive_ff, out_drive_in;
   logic [EXT_BITS-1:0]        out_ext_ff, out_ext_in;

   // combinational helpers
   logic signed [POS_BITS-1:0]   lo_s, hi_s, lo_raw, hi_raw;
   logic                         req_take, span_pos, jump;
   logic signed [REM_BITS-1:0]   num_s, span_x;
   logic [REM_BITS-1:0]          rem_sh, span_u;
   logic [EXT_BITS-1:0]          tgt_ext;
   logic signed [SPAN_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  mul_p, tgt_sum;
   logic signed [SPAN_BITS-1:0]  diff;
   logic [SPAN_BITS-1:0]         diff_mag;
   logic [VEL_BITS-1:0]          step_u;

   pssl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign lo_s     = cfg.stroke_lower;
   assign hi_s     = cfg.stroke_upper;
   assign req_take = req_bus.valid && (state_ff == ST_IDLE);
   assign span_pos = !span_ff[SPAN_BITS-1] && (span_ff != '0);
   assign num_s    = rem_ff;
   assign span_x   = REM_BITS'(span_ff);
   assign span_u   = span_x;
   assign rem_sh   = {rem_ff[REM_BITS-2:0], 1'b0};
   assign step_u   = prod_ff[TIME_FRAC+VEL_BITS-1:TIME_FRAC];
   assign jump     = (cfg.velocity_limit == '0) || (dt_ff == '0);
   assign tgt_sum  = PROD_BITS'(lo_s) + (prod_ff >>> FRAC_BITS);
   assign diff     = SPAN_BITS'(tgt_pos_ff) - SPAN_BITS'(command_ff);
   assign diff_mag = diff[SPAN_BITS-1] ? -diff : diff;

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = (state_ff == ST_SEND);
   assign rsp_bus.servo_setpoint = out_setpoint_ff;
   assign rsp_bus.travel_lower   = out_lower_ff;
   assign rsp_bus.travel_upper   = out_upper_ff;
   assign rsp_bus.drive_on       = out_drive_ff;
   assign rsp_bus.extension_now  = out_ext_ff;

   // target extension by mode
   always_comb begin
      case (mode_ff)
         MODE_HOLD:     tgt_ext = ext_ff;
         MODE_EXTEND:   tgt_ext = FULL_EXT;
         MODE_CONTRACT: tgt_ext = '0;
         MODE_POSITION: tgt_ext = (tfrac_ff > FULL_EXT) ? FULL_EXT : tfrac_ff;
         default:       tgt_ext = '0;
      endcase
   end

   // shared multiplier: stroke scaling, then velocity step
   always_comb begin
      if (state_ff == ST_STEP) begin
         mul_a = SPAN_BITS'(cfg.velocity_limit);
         mul_b = MUL_B_BITS'(dt_ff);
      end else begin
         mul_a = span_ff;
         mul_b = MUL_B_BITS'(tgt_ext);
      end
   end
   assign mul_p = mul_a * mul_b;

   // raw travel limits before clamping
   always_comb begin
      lo_raw = lo_s;
      hi_raw = hi_s;
      if (cfg.lock_idle && (mode_ff == MODE_HOLD)) begin
         lo_raw = present_pos_ff;
         hi_raw = present_pos_ff;
      end else if (mode_ff == MODE_EXTEND) begin
         lo_raw = present_pos_ff;
      end else if (mode_ff == MODE_CONTRACT) begin
         hi_raw = present_pos_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      seeded_in       = seeded_ff;
      command_in      = command_ff;
      present_pos_in  = present_pos_ff;
      present_frac_in = present_frac_ff;
      kind_in         = kind_ff;
      mode_in         = mode_ff;
      tfrac_in        = tfrac_ff;
      dt_in           = dt_ff;
      upd_frac_in     = upd_frac_ff;
      span_in         = span_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      ext_in          = ext_ff;
      tgt_pos_in      = tgt_pos_ff;
      prod_in         = prod_ff;
      lim_lo_in       = lim_lo_ff;
      lim_hi_in       = lim_hi_ff;
      out_setpoint_in = out_setpoint_ff;
      out_lower_in    = out_lower_ff;
      out_upper_in    = out_upper_ff;
      out_drive_in    = out_drive_ff;
      out_ext_in      = out_ext_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && cfg.unit_enabled) begin
               kind_in     = req_bus.kind;
               mode_in     = pssl_mode_type'(req_bus.drive_mode);
               tfrac_in    = req_bus.target_fraction;
               dt_in       = req_bus.time_step;
               upd_frac_in = (req_bus.kind == KIND_MEASURE) ||
                             (!seeded_ff && req_bus.position_valid);
               if (req_bus.kind == KIND_MEASURE) begin
                  if (req_bus.position_valid) begin
                     present_pos_in = req_bus.measured_position;
                  end
               end else begin
                  // first drive after reset seeds the command
                  if (!seeded_ff && req_bus.position_valid) begin
                     present_pos_in = req_bus.measured_position;
                     command_in     = req_bus.measured_position;
                  end
                  seeded_in = 1'b1;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            span_in  = SPAN_BITS'(hi_s) - SPAN_BITS'(lo_s);
            rem_in   = REM_BITS'(present_pos_ff) - REM_BITS'(lo_s);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            quo_in = '0;
            cnt_in = CNT_BITS'(FRAC_BITS - 1);
            if (!span_pos) begin
               ext_in   = present_frac_ff;
               state_in = ST_STORE;
            end else if (num_s <= 0) begin
               ext_in   = '0;
               state_in = ST_STORE;
            end else if (num_s >= span_x) begin
               ext_in   = FULL_EXT;
               state_in = ST_STORE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one restoring step per cycle; remainder stays below the span
            if (rem_sh >= span_u) begin
               rem_in = rem_sh - span_u;
               quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               ext_in   = EXT_BITS'(quo_in);
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (span_pos && upd_frac_ff) begin
               present_frac_in = ext_ff;
            end
            state_in = (kind_ff == KIND_MEASURE) ? ST_IDLE : ST_SCALE;
         end
         ST_SCALE: begin
            prod_in   = mul_p;
            lim_lo_in = clamp_pos(lo_raw, lo_s, hi_s);
            lim_hi_in = clamp_pos(hi_raw, lo_s, hi_s);
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            tgt_pos_in = tgt_sum[POS_BITS-1:0];
            prod_in    = mul_p;
            state_in   = ST_MOVE;
         end
         ST_MOVE: begin
            if (jump || (diff_mag <= SPAN_BITS'(step_u))) begin
               command_in = tgt_pos_ff;
            end else if (!diff[SPAN_BITS-1]) begin
               command_in = command_ff + POS_BITS'(step_u);
            end else begin
               command_in = command_ff - POS_BITS'(step_u);
            end
            out_setpoint_in = command_in;
            if (lim_lo_ff > lim_hi_ff) begin
               out_lower_in = lim_hi_ff;
               out_upper_in = lim_lo_ff;
            end else begin
               out_lower_in = lim_lo_ff;
               out_upper_in = lim_hi_ff;
            end
            out_drive_in = (mode_ff != MODE_HOLD) || cfg.lock_idle;
            out_ext_in   = ext_ff;
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         seeded_ff       <= 1'b0;
         command_ff      <= '0;
         present_pos_ff  <= '0;
         present_frac_ff <= '0;
      end else begin
         state_ff        <= state_in;
         seeded_ff       <= seeded_in;
         command_ff      <= command_in;
         present_pos_ff  <= present_pos_in;
         present_frac_ff <= present_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      mode_ff         <= mode_in;
      tfrac_ff        <= tfrac_in;
      dt_ff           <= dt_in;
      upd_frac_ff     <= upd_frac_in;
      span_ff         <= span_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      cnt_ff          <= cnt_in;
      ext_ff          <= ext_in;
      tgt_pos_ff      <= tgt_pos_in;
      prod_ff         <= prod_in;
      lim_lo_ff       <= lim_lo_in;
      lim_hi_ff       <= lim_hi_in;
      out_setpoint_ff <= out_setpoint_in;
      out_lower_ff    <= out_lower_in;
      out_upper_ff    <= out_upper_in;
      out_drive_ff    <= out_drive_in;
      out_ext_ff      <= out_ext_in;
   end

endmodule

`default_nettype wire

// File: tb/piston_setpoint_slew_limiter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piston_setpoint_slew_limiter_core_tb
// Self-checking regression of the piston setpoint slew limiter. A queue-fed
// driver offers measure and drive transactions in random bursts. A clocked
// monitor takes results under changing stall patterns and compares each one
// with the setpoint predicted for it. The stroke, velocity and lock settings
// change between phases over the APB port, with a readback of every register.
// ----------------------------------------------------------------------------

module piston_setpoint_slew_limiter_core_tb;
   import pssl_pkg::*;

   localparam int    CLK_PERIOD       = 10;
   localparam int    RESET_CYCLES     = 12;
   localparam int    BLOCK_LATENCY    = 40;     // wait for a measure that may still be in work
   localparam int    PHASES           = 8;
   localparam int    TICKS_PER_PHASE  = 200;
   localparam int    LONG_HOLDS       = 2;
   localparam int    LONG_HOLD_CYCLES = 400;
   localparam int    MAX_PRINTED      = 40;
   localparam longint FULL_STROKE     = longint'(1) << FRAC_BITS;
   localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
   localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

   typedef struct {
      logic                       kind;
      logic signed [POS_BITS-1:0] meas;
      logic                       pvalid;
      pssl_mode_type              mode;
      logic [EXT_BITS-1:0]        tfrac;
      logic [TIME_BITS-1:0]       tstep;
   } actuator_tick_type;

   typedef struct {
      logic signed [POS_BITS-1:0] setpoint;
      logic signed [POS_BITS-1:0] lower;
      logic signed [POS_BITS-1:0] upper;
      logic                       drive_on;
      logic [EXT_BITS-1:0]        extension;
   } setpoint_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   pssl_req_if req_if ();
   pssl_rsp_if rsp_if ();

   piston_setpoint_slew_limiter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus and expectations
   actuator_tick_type tick_queue[$];
   setpoint_type      pending_setpoints[$];
   actuator_tick_type offered;

   // predictor copy of the block
   pssl_cfg_type cfg_shadow;
   longint       cmd_pos;
   longint       present_pos;
   longint       present_ext;
   bit           seeded;

   int fail_count;
   int drive_count;
   int measure_count;
   int dropped_count;
   int results_checked;
   int write_count;

   // sender bursts and receiver stalls
   int          gap_left;
   int          burst_left;
   int          hold_left;
   int          holds_done;
   int          stall_style;
   int          style_left;
   logic [15:0] stall_mask;
   logic [3:0]  mask_pos;

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTED)
         $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint extension_along(longint pos, longint lo, longint span);
      longint rem;
      longint quo;
      rem = pos - lo;
      quo = 0;
      if (rem <= 0)
         return 0;
      if (rem >= span)
         return FULL_STROKE;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem <<< 1;
         quo = quo <<< 1;
         if (rem >= span) begin
            rem = rem - span;
            quo = quo | 1;
         end
      end
      return quo;
   endfunction

   function automatic longint pin_to_stroke(longint v, longint lo, longint hi);
      if (v < lo)
         v = lo;
      if (v > hi)
         v = hi;
      return v;
   endfunction

   function automatic void predict_setpoint(actuator_tick_type t);
      longint       lo;
      longint       hi;
      longint       span;
      longint       meas;
      longint       cur_ext;
      longint       tgt_ext;
      longint       tgt_pos;
      longint       step;
      longint       to_target;
      longint       lim_lo;
      longint       lim_hi;
      longint       swap_v;
      setpoint_type sp;
      lo   = longint'($signed(cfg_shadow.stroke_lower));
      hi   = longint'($signed(cfg_shadow.stroke_upper));
      span = hi - lo;
      meas = longint'(t.meas);
      if (!cfg_shadow.unit_enabled) begin
         dropped_count++;
         return;
      end
      if (t.kind == KIND_MEASURE) begin
         measure_count++;
         if (t.pvalid)
            present_pos = meas;
         if (span > 0)
            present_ext = extension_along(present_pos, lo, span);
         return;
      end
      drive_count++;
      // first drive after reset seeds the command, but only from a valid position
      if (!seeded) begin
         if (t.pvalid) begin
            present_pos = meas;
            cmd_pos     = meas;
            if (span > 0)
               present_ext = extension_along(meas, lo, span);
         end
         seeded = 1'b1;
      end
      cur_ext = (span > 0) ? extension_along(present_pos, lo, span) : present_ext;
      case (t.mode)
         MODE_HOLD:     tgt_ext = cur_ext;
         MODE_EXTEND:   tgt_ext = FULL_STROKE;
         MODE_CONTRACT: tgt_ext = 0;
         default:       tgt_ext = (longint'(t.tfrac) > FULL_STROKE) ? FULL_STROKE
                                                                    : longint'(t.tfrac);
      endcase
      tgt_pos = lo + ((tgt_ext * span) >>> FRAC_BITS);
      if (cfg_shadow.velocity_limit == 0 || t.tstep == 0) begin
         cmd_pos = tgt_pos;
      end else begin
         step = (longint'(cfg_shadow.velocity_limit) * longint'(t.tstep)) >>> TIME_FRAC;
         to_target = tgt_pos - cmd_pos;
         if (to_target <= step && -to_target <= step)
            cmd_pos = tgt_pos;
         else if (to_target > 0)
            cmd_pos = cmd_pos + step;
         else
            cmd_pos = cmd_pos - step;
      end
      lim_lo = lo;
      lim_hi = hi;
      if (cfg_shadow.lock_idle && t.mode == MODE_HOLD) begin
         lim_lo = present_pos;
         lim_hi = present_pos;
      end else if (t.mode == MODE_EXTEND) begin
         lim_lo = present_pos;
      end else if (t.mode == MODE_CONTRACT) begin
         lim_hi = present_pos;
      end
      // with an inverted stroke both limits land on the upper end
      lim_lo = pin_to_stroke(lim_lo, lo, hi);
      lim_hi = pin_to_stroke(lim_hi, lo, hi);
      if (lim_lo > lim_hi) begin
         swap_v = lim_lo;
         lim_lo = lim_hi;
         lim_hi = swap_v;
      end
      sp.setpoint  = POS_BITS'(cmd_pos);
      sp.lower     = POS_BITS'(lim_lo);
      sp.upper     = POS_BITS'(lim_hi);
      sp.drive_on  = (t.mode != MODE_HOLD) || cfg_shadow.lock_idle;
      sp.extension = EXT_BITS'(cur_ext);
      pending_setpoints.push_back(sp);
   endfunction

   // ------------------------------------------------------------------------
   // Sender: one transaction held until taken, bursts with random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sender
      actuator_tick_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     = 0;
         burst_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            predict_setpoint(offered);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               nxt     = tick_queue.pop_front();
               offered = nxt;
               req_if.kind              <= nxt.kind;
               req_if.measured_position <= nxt.meas;
               req_if.position_valid    <= nxt.pvalid;
               req_if.drive_mode        <= nxt.mode;
               req_if.target_fraction   <= nxt.tfrac;
               req_if.time_step         <= nxt.tstep;
               req_if.valid             <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: checks each result, stalls on its own pattern
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : receiver
      setpoint_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    = 0;
         holds_done   = 0;
         style_left   = 0;
         mask_pos     = '0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (pending_setpoints.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = pending_setpoints.pop_front();
               if (rsp_if.servo_setpoint !== want.setpoint)
                  report_mismatch($sformatf("servo_setpoint %h, want %h",
                                            rsp_if.servo_setpoint, want.setpoint));
               if (rsp_if.travel_lower !== want.lower)
                  report_mismatch($sformatf("travel_lower %h, want %h",
                                            rsp_if.travel_lower, want.lower));
               if (rsp_if.travel_upper !== want.upper)
                  report_mismatch($sformatf("travel_upper %h, want %h",
                                            rsp_if.travel_upper, want.upper));
               if (rsp_if.drive_on !== want.drive_on)
                  report_mismatch($sformatf("drive_on %b, want %b",
                                            rsp_if.drive_on, want.drive_on));
               if (rsp_if.extension_now !== want.extension)
                  report_mismatch($sformatf("extension_now %h, want %h",
                                            rsp_if.extension_now, want.extension));
            end
         end
         // long hold-off lets the block back up into the request side
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (holds_done < LONG_HOLDS && drive_count >= 300 + 600 * holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               stall_style = $urandom_range(0, 2);
               style_left  = $urandom_range(40, 400);
               stall_mask  = 16'($urandom | 1);
            end else begin
               style_left--;
            end
            case (stall_style)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= stall_mask[mask_pos];
               default: rsp_if.ready <= ($urandom_range(0, 9) > 3);
            endcase
            mask_pos++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // APB access
   // ------------------------------------------------------------------------
   task automatic csr_write(input int index, input logic [DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'(index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      write_count++;
      case (index)
         REG_STROKE_LOWER:   cfg_shadow.stroke_lower   = data;
         REG_STROKE_UPPER:   cfg_shadow.stroke_upper   = data;
         REG_VELOCITY_LIMIT: cfg_shadow.velocity_limit = data[VEL_BITS-1:0];
         REG_LOCK_IDLE:      cfg_shadow.lock_idle      = data[0];
         REG_UNIT_ENABLED:   cfg_shadow.unit_enabled   = data[0];
         default: ;
      endcase
   endtask

   task automatic check_register(input int index);
      logic [DATA_BITS-1:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_BITS'(index * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_STROKE_LOWER:   want = cfg_shadow.stroke_lower;
         REG_STROKE_UPPER:   want = cfg_shadow.stroke_upper;
         REG_VELOCITY_LIMIT: want = DATA_BITS'(cfg_shadow.velocity_limit);
         REG_LOCK_IDLE:      want = DATA_BITS'(cfg_shadow.lock_idle);
         default:            want = DATA_BITS'(cfg_shadow.unit_enabled);
      endcase
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d reads %h, want %h", index, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_stroke(input logic [POS_BITS-1:0] lo, input logic [POS_BITS-1:0] hi,
                                 input logic [VEL_BITS-1:0] vel, input logic lock);
      csr_write(REG_STROKE_LOWER, lo);
      csr_write(REG_STROKE_UPPER, hi);
      // spare upper bits are noise and must be dropped
      csr_write(REG_VELOCITY_LIMIT, {$urandom_range(0, 1) == 1, vel});
      csr_write(REG_LOCK_IDLE, ($urandom & ~32'd1) | DATA_BITS'(lock));
      for (int i = 0; i < NUM_REGS; i++)
         check_register(i);
   endtask

   // ------------------------------------------------------------------------
   // Transaction builders
   // ------------------------------------------------------------------------
   function automatic logic [POS_BITS-1:0] pick_position();
      longint          lo;
      longint          span;
      longint unsigned r;
      int              sel;
      lo   = longint'($signed(cfg_shadow.stroke_lower));
      span = longint'($signed(cfg_shadow.stroke_upper)) - lo;
      r    = {$urandom, $urandom};
      sel  = $urandom_range(0, 9);
      if (span < 0) begin
         lo   = lo + span;
         span = -span;
      end
      case (sel)
         0:       return POS_BITS'(lo);
         1:       return POS_BITS'(lo + span);
         2:       return POS_BITS'(lo + $urandom_range(0, 8) - 4);
         3:       return POS_BITS'(lo + span + $urandom_range(0, 8) - 4);
         4:       return $urandom;
         5:       return ($urandom_range(0, 1) == 1) ? POS_MAX : POS_MIN;
         default: return POS_BITS'(lo + longint'(r % longint'(span + 1)));
      endcase
   endfunction

   function automatic actuator_tick_type make_measure(input logic pv,
                                                      input logic [POS_BITS-1:0] pos);
      actuator_tick_type t;
      t.kind   = KIND_MEASURE;
      t.meas   = pos;
      t.pvalid = pv;
      t.mode   = pssl_mode_type'($urandom_range(0, 3));
      t.tfrac  = EXT_BITS'($urandom);
      t.tstep  = TIME_BITS'($urandom);
      return t;
   endfunction

   function automatic actuator_tick_type make_drive(input pssl_mode_type m);
      actuator_tick_type t;
      int                pick;
      t.kind   = KIND_DRIVE;
      t.meas   = $urandom;
      t.pvalid = 1'($urandom_range(0, 1));
      t.mode   = m;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         t.tfrac = EXT_BITS'($urandom_range(0, FULL_EXT));
      else if (pick < 9)
         t.tfrac = EXT_BITS'($urandom);
      else
         t.tfrac = ($urandom_range(0, 1) == 1) ? FULL_EXT : '0;
      pick = $urandom_range(0, 19);
      if (pick < 3)
         t.tstep = '0;
      else if (pick == 3)
         t.tstep = '1;
      else if (pick < 13)
         t.tstep = TIME_BITS'($urandom_range(1, 2047));
      else
         t.tstep = TIME_BITS'($urandom);
      return t;
   endfunction

   task automatic load_random_ticks(input int count);
      int                made;
      int                shape;
      actuator_tick_type t;
      made = 0;
      while (made < count) begin
         shape = $urandom_range(0, 9);
         if (shape <= 5) begin
            // measure-then-drive, as a control loop issues them
            tick_queue.push_back(make_measure($urandom_range(0, 9) != 0, pick_position()));
            tick_queue.push_back(make_drive(pssl_mode_type'($urandom_range(0, 3))));
            made += 2;
         end else if (shape <= 7) begin
            tick_queue.push_back(make_drive(pssl_mode_type'($urandom_range(0, 3))));
            made++;
         end else if (shape == 8) begin
            tick_queue.push_back(make_measure(1'($urandom_range(0, 1)), pick_position()));
            made++;
         end else begin
            t = make_measure(1'($urandom_range(0, 1)), $urandom);
            t.kind = 1'($urandom_range(0, 1));
            tick_queue.push_back(t);
            made++;
         end
      end
   endtask

   task automatic wait_for_idle();
      while (tick_queue.size() != 0 || req_if.valid || pending_setpoints.size() != 0)
         @(posedge clock);
      repeat (BLOCK_LATENCY) @(posedge clock);
   endtask

   task automatic load_directed_ticks();
      actuator_tick_type t;
      tick_queue.push_back(make_measure(1'b1, POS_BITS'(32768)));
      // first drive: seeds only if its position is valid, either way is legal
      t = make_drive(MODE_HOLD);
      t.meas   = pick_position();
      t.pvalid = 1'($urandom_range(0, 1));
      t.tstep  = '0;
      tick_queue.push_back(t);
      t = make_drive(MODE_EXTEND);
      t.tstep = '0;
      tick_queue.push_back(t);
      t = make_drive(MODE_CONTRACT);
      t.tstep = '1;
      tick_queue.push_back(t);
      t = make_drive(MODE_POSITION);
      t.tfrac = '0;
      tick_queue.push_back(t);
      t = make_drive(MODE_POSITION);
      t.tfrac = FULL_EXT;
      tick_queue.push_back(t);
      t = make_drive(MODE_POSITION);
      t.tfrac = '1;                       // beyond full stroke
      tick_queue.push_back(t);
      t = make_drive(MODE_POSITION);
      t.tfrac = FULL_EXT + 1;
      tick_queue.push_back(t);
      tick_queue.push_back(make_measure(1'b0, POS_MAX));   // invalid: position kept
      tick_queue.push_back(make_drive(MODE_HOLD));
      tick_queue.push_back(make_measure(1'b1, POS_MIN));
      tick_queue.push_back(make_drive(MODE_HOLD));
      tick_queue.push_back(make_drive(MODE_EXTEND));
      tick_queue.push_back(make_measure(1'b1, POS_MAX));
      tick_queue.push_back(make_drive(MODE_CONTRACT));
      tick_queue.push_back(make_measure(1'b1, '0));
      t = make_drive(MODE_POSITION);
      t.tfrac = EXT_BITS'(21845);
      tick_queue.push_back(t);
      tick_queue.push_back(make_measure(1'b1, POS_BITS'(65536)));
      tick_queue.push_back(make_drive(MODE_HOLD));
      tick_queue.push_back(make_measure(1'b1, POS_BITS'(1)));
      t = make_drive(MODE_POSITION);
      t.tfrac = EXT_BITS'(1);
      t.tstep = TIME_BITS'(1);
      tick_queue.push_back(t);
   endtask

   // ------------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------------
   initial begin : watchdog
      #5_000_000;
      $display("piston_setpoint_slew_limiter_core regression: fail");
      $finish;
   end

   initial begin : regression
      logic [POS_BITS-1:0] lo_pick;
      clock       = 1'b0;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_if.valid             = 1'b0;
      req_if.kind              = KIND_MEASURE;
      req_if.measured_position = '0;
      req_if.position_valid    = 1'b0;
      req_if.drive_mode        = MODE_HOLD;
      req_if.target_fraction   = '0;
      req_if.time_step         = '0;
      rsp_if.ready             = 1'b0;
      cfg_shadow   = CFG_RESET;
      cmd_pos      = 0;
      present_pos  = 0;
      present_ext  = 0;
      seeded       = 1'b0;
      fail_count   = 0;
      drive_count  = 0;
      measure_count   = 0;
      dropped_count   = 0;
      results_checked = 0;
      write_count     = 0;
      stall_style     = 0;
      stall_mask      = '1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_REGS; i++)
         check_register(i);
      load_directed_ticks();
      wait_for_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_stroke(POS_BITS'(-100 * 65536), POS_BITS'(250 * 65536),
                              VEL_BITS'(20 * 65536), 1'b1);
            1: program_stroke(POS_MIN, POS_MAX, '1, 1'b0);
            2: begin
               // empty stroke: extension comes from the stored fraction
               lo_pick = $urandom;
               program_stroke(lo_pick, lo_pick, VEL_BITS'($urandom),
                              1'($urandom_range(0, 1)));
            end
            3: program_stroke('0, POS_BITS'(40 * 65536), VEL_BITS'(1), 1'b0);
            4: program_stroke(POS_BITS'(5 * 65536), POS_BITS'(-5 * 65536),
                              VEL_BITS'($urandom_range(1, 65535)), 1'b1);
            5: begin
               csr_write(REG_UNIT_ENABLED, $urandom & ~32'd1);
               load_random_ticks(40);
               wait_for_idle();
               csr_write(REG_UNIT_ENABLED, $urandom | 32'd1);
               // writes past the register list must not land anywhere
               csr_write($urandom_range(NUM_REGS, (1 << (ADDR_BITS - 2)) - 1), $urandom);
               program_stroke(POS_BITS'(-3 * 65536), POS_BITS'(2000 * 65536),
                              VEL_BITS'(500 * 65536), 1'b0);
            end
            default: begin
               lo_pick = $urandom;
               program_stroke(lo_pick,
                              ($urandom_range(0, 1) == 1)
                                 ? lo_pick + POS_BITS'($urandom_range(0, 1 << 24))
                                 : POS_BITS'($urandom),
                              ($urandom_range(0, 3) == 0) ? '0 : VEL_BITS'($urandom >> 8),
                              1'($urandom_range(0, 1)));
            end
         endcase
         load_random_ticks(TICKS_PER_PHASE);
         wait_for_idle();
      end

      $display("covered %0d drive and %0d measure transactions over %0d setting phases,",
               drive_count, measure_count, PHASES + 1);
      $display("%0d results checked, %0d dropped while disabled, %0d register writes",
               results_checked, dropped_count, write_count);
      if (fail_count == 0 && pending_setpoints.size() == 0)
         $display("piston_setpoint_slew_limiter_core regression: pass");
      else
         $display("piston_setpoint_slew_limiter_core regression: fail");
      $finish;
   end

endmodule
